@@ src/htc_pkg.sv @@
// ----------------------------------------------------------------------------
// htc_pkg: shared types and constants for humidity/temperature compensation
// Fixed-point constants, stage payload structs and decimal digit helpers.
// ----------------------------------------------------------------------------
package htc_pkg;

  localparam int NUM_STAGES = 7;

  // Offset register reset: minus forty degrees in hundredths
  localparam logic signed [13:0] TEMP_OFFSET_RESET = -14'sd4000;

  localparam logic [13:0] ERROR_TENTHS  = 14'd9999;
  localparam logic [13:0] HUMI_CLAMP_HI = 14'd1000;
  localparam logic [13:0] HUMI_CLAMP_LO = 14'd1;

  // Humidity is carried in units of 1e-7 %RH
  localparam logic signed [15:0] TEMP_REF_CENTI  = 16'sd2500;
  localparam logic [15:0]        HUMI_SLOPE_BASE = 16'd1000;
  localparam logic [18:0]        LIN_COEF        = 19'd405000;
  localparam logic signed [35:0] LIN_OFFSET      = 36'sd40000000;
  localparam logic signed [35:0] HUMI_MAX        = 36'sd1000000000;
  localparam logic signed [35:0] HUMI_MIN        = 36'sd1000000;
  localparam logic [19:0]        HUMI_TENTH      = 20'd1000000;
  localparam logic [20:0]        HUMI_RECIP      = 21'd1099511;  // floor(2^40 / 1e6)

  // Reciprocals for small divisors, exact below 10000
  localparam logic [15:0] RECIP_10   = 16'd52429;  // >> 19
  localparam logic [13:0] RECIP_100  = 14'd10486;  // >> 20
  localparam logic [13:0] RECIP_1000 = 14'd8389;   // >> 23

  typedef struct packed {
    logic [3:0]  q1000;
    logic [6:0]  q100;
    logic [9:0]  q10;
    logic [13:0] x;
  } dquot_t;

  typedef struct packed {
    logic [3:0] thou;
    logic [3:0] hund;
    logic [3:0] tens;
    logic [3:0] units;
  } digits_t;

  typedef struct packed {
    logic               err;
    logic [11:0]        h;
    logic signed [15:0] tc;
    logic signed [15:0] tcm;
    logic [15:0]        hw;
  } s1_t;

  typedef struct packed {
    logic               err;
    logic               tneg;
    logic [23:0]        hsq;
    logic [30:0]        p1;
    logic signed [32:0] comp;
    logic [30:0]        tq;
  } s2_t;

  typedef struct packed {
    logic               err;
    logic signed [35:0] v;
    logic signed [14:0] temp;
    logic [13:0]        tabs;
  } s3_t;

  typedef struct packed {
    logic               err;
    logic               big;
    logic               small_v;
    logic [29:0]        v30;
    logic [10:0]        q0;
    logic signed [14:0] temp;
    dquot_t             tq;
  } s4_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        humi;
    digits_t            tdig;
  } s5_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        humi;
    digits_t            tdig;
    dquot_t             hq;
  } s6_t;

  typedef struct packed {
    logic signed [14:0] temp;
    logic [13:0]        humi;
    digits_t            tdig;
    digits_t            hdig;
  } s7_t;

  // Quotients by 1000, 100 and 10, each from one constant multiply
  function automatic dquot_t digit_quot(input logic [13:0] x);
    logic [27:0] p1000;
    logic [27:0] p100;
    logic [29:0] p10;
    dquot_t      q;
    p1000   = x * RECIP_1000;
    p100    = x * RECIP_100;
    p10     = x * RECIP_10;
    q.q1000 = p1000[26:23];
    q.q100  = p100[26:20];
    q.q10   = p10[28:19];
    q.x     = x;
    return q;
  endfunction

  // Digit = quotient minus ten times the next coarser quotient
  function automatic digits_t digit_split(input dquot_t q);
    digits_t d;
    d.thou  = q.q1000;
    d.hund  = 4'(q.q100 - {q.q1000, 3'b000} - {2'b00, q.q1000, 1'b0});
    d.tens  = 4'(q.q10 - {q.q100, 3'b000} - {2'b00, q.q100, 1'b0});
    d.units = 4'(q.x - {1'b0, q.q10, 3'b000} - {3'b000, q.q10, 1'b0});
    return d;
  endfunction

endpackage

@@ src/humidity_temperature_compensation.sv @@
// ----------------------------------------------------------------------------
// humidity_temperature_compensation: sensor reading to tenths and digits
// Temperature = ticks/100 + offset, humidity = quadratic in ticks with
// temperature compensation, clamped 0.1..100 %RH, both split into digits.
// ----------------------------------------------------------------------------
//
//  channel | ports                        | carries
//  --------+------------------------------+-----------------------------------
//  in      | in_tvalid/in_tready/tdata/tuser | raw humidity, temperature, error
//  out     | out_tvalid/out_tready/tdata  | tenths and eight decimal digits
//  cfg     | cfg_we/cfg_wdata             | temperature offset, hundredths
//
// Seven-stage pipeline, one item per cycle while out_tready is high. An accepted
// item passes stage registers s1_r to s7_r in order; out_tvalid is stage 7's valid bit.
// Stage depth is set by one multiply (humidity products, /1e6 reciprocal,
// digit reciprocals) or one wide add per stage.
// Each stage holds a valid bit; a stage loads when it is empty or the one
// after it moves, so bubbles collapse under out_tready low and nothing drops.
// rst_n (synchronous) clears the valid bits and loads the offset to -40.00.
// Offset writes take effect for items accepted after the write.

module humidity_temperature_compensation (
  input  logic        clk,
  input  logic        rst_n,
  // in_tdata: raw_humidity[11:0], raw_temperature[25:12], zero fill [31:26]
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,
  // in_tuser: sensor_error[0]
  input  logic        in_tuser,
  // out_tdata: temp_tenths[14:0], humi_tenths[28:15],
  //   temp_digit_thousands[32:29], temp_digit_hundreds[36:33],
  //   temp_digit_tens[40:37], temp_digit_units[44:41],
  //   humi_digit_thousands[48:45], humi_digit_hundreds[52:49],
  //   humi_digit_tens[56:53], humi_digit_units[60:57], zero fill [63:61]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata
);

  localparam int NS = htc_pkg::NUM_STAGES;

  logic [13:0]    off_r, off_nxt;
  logic [NS:1]    vld_r, vld_nxt;
  logic [NS+1:1]  rdy;

  htc_pkg::s1_t s1_r, s1_nxt;
  htc_pkg::s2_t s2_r, s2_nxt;
  htc_pkg::s3_t s3_r, s3_nxt;
  htc_pkg::s4_t s4_r, s4_nxt;
  htc_pkg::s5_t s5_r, s5_nxt;
  htc_pkg::s6_t s6_r, s6_nxt;
  htc_pkg::s7_t s7_r, s7_nxt;

  // ---------------- offset register ----------------
  assign off_nxt = cfg_we ? cfg_wdata : off_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      off_r <= htc_pkg::TEMP_OFFSET_RESET;
    end else begin
      off_r <= off_nxt;
    end
  end

  // ---------------- pipeline control ----------------
  // A stage may load when empty or when its successor loads.
  always_comb begin
    rdy[NS+1] = out_tready;
    for (int i = NS; i >= 1; i--) begin
      rdy[i] = !vld_r[i] || rdy[i+1];
    end
  end

  always_comb begin
    vld_nxt[1] = rdy[1] ? in_tvalid : vld_r[1];
    for (int i = 2; i <= NS; i++) begin
      vld_nxt[i] = rdy[i] ? vld_r[i-1] : vld_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_tready  = rdy[1];
  assign out_tvalid = vld_r[NS];

  // ---------------- stage 1: temperature in hundredths ----------------
  always_comb begin
    logic signed [15:0] off_ext;
    off_ext    = $signed({{2{off_r[13]}}, off_r});
    s1_nxt.err = in_tuser;
    s1_nxt.h   = in_tdata[11:0];
    s1_nxt.tc  = $signed({2'b00, in_tdata[25:12]}) + off_ext;
    s1_nxt.tcm = s1_nxt.tc - htc_pkg::TEMP_REF_CENTI;
    s1_nxt.hw  = htc_pkg::HUMI_SLOPE_BASE + {1'b0, in_tdata[11:0], 3'b000};
  end

  // ---------------- stage 2: products ----------------
  always_comb begin
    logic [15:0]        tmag;
    logic signed [32:0] comp_w;
    logic signed [16:0] hw_s;
    hw_s        = $signed({1'b0, s1_r.hw});
    comp_w      = s1_r.tcm * hw_s;
    tmag        = s1_r.tc[15] ? 16'(-s1_r.tc) : 16'(s1_r.tc);
    s2_nxt.err  = s1_r.err;
    s2_nxt.tneg = s1_r.tc[15];
    s2_nxt.hsq  = s1_r.h * s1_r.h;
    s2_nxt.p1   = s1_r.h * htc_pkg::LIN_COEF;
    s2_nxt.comp = comp_w;
    s2_nxt.tq   = tmag[14:0] * htc_pkg::RECIP_10;  // |tc| / 10 in [30:19]
  end

  // ---------------- stage 3: humidity sum, signed temperature ----------------
  always_comb begin
    logic [28:0]        h28;
    logic [11:0]        tq;
    logic signed [14:0] tq_s;
    h28  = {s2_r.hsq, 5'b00000} - {3'b000, s2_r.hsq, 2'b00};
    tq   = s2_r.tq[30:19];
    tq_s = $signed({3'b000, tq});
    s3_nxt.err  = s2_r.err;
    s3_nxt.v    = $signed({5'b00000, s2_r.p1}) - $signed({7'b0000000, h28})
                  - htc_pkg::LIN_OFFSET + $signed({{3{s2_r.comp[32]}}, s2_r.comp});
    s3_nxt.temp = s2_r.err  ? $signed({1'b0, htc_pkg::ERROR_TENTHS}) :
                  s2_r.tneg ? -tq_s : tq_s;
    s3_nxt.tabs = s2_r.err ? htc_pkg::ERROR_TENTHS : {2'b00, tq};
  end

  // ---------------- stage 4: clamp flags, /1e6 estimate ----------------
  always_comb begin
    logic [50:0] prod;
    prod           = s3_r.v[29:0] * htc_pkg::HUMI_RECIP;
    s4_nxt.err     = s3_r.err;
    s4_nxt.big     = s3_r.v > htc_pkg::HUMI_MAX;
    s4_nxt.small_v = s3_r.v < htc_pkg::HUMI_MIN;
    s4_nxt.v30     = s3_r.v[29:0];
    s4_nxt.q0      = prod[50:40];  // exact quotient or one below
    s4_nxt.temp    = s3_r.temp;
    s4_nxt.tq      = htc_pkg::digit_quot(s3_r.tabs);
  end

  // ---------------- stage 5: quotient correction, humidity tenths ----------------
  always_comb begin
    logic [30:0] qm;
    logic [30:0] rem;
    logic [10:0] hq;
    qm  = s4_r.q0 * htc_pkg::HUMI_TENTH;
    rem = {1'b0, s4_r.v30} - qm;
    hq  = (rem >= 31'(htc_pkg::HUMI_TENTH)) ? s4_r.q0 + 11'd1 : s4_r.q0;
    s5_nxt.temp = s4_r.temp;
    priority if (s4_r.err) begin
      s5_nxt.humi = htc_pkg::ERROR_TENTHS;
    end else if (s4_r.big) begin
      s5_nxt.humi = htc_pkg::HUMI_CLAMP_HI;
    end else if (s4_r.small_v) begin
      s5_nxt.humi = htc_pkg::HUMI_CLAMP_LO;
    end else begin
      s5_nxt.humi = {3'b000, hq};
    end
    s5_nxt.tdig = htc_pkg::digit_split(s4_r.tq);
  end

  // ---------------- stage 6: humidity digit quotients ----------------
  always_comb begin
    s6_nxt.temp = s5_r.temp;
    s6_nxt.humi = s5_r.humi;
    s6_nxt.tdig = s5_r.tdig;
    s6_nxt.hq   = htc_pkg::digit_quot(s5_r.humi);
  end

  // ---------------- stage 7: output register ----------------
  always_comb begin
    s7_nxt.temp = s6_r.temp;
    s7_nxt.humi = s6_r.humi;
    s7_nxt.tdig = s6_r.tdig;
    s7_nxt.hdig = htc_pkg::digit_split(s6_r.hq);
  end

  // Payload registers, no reset
  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      s1_r <= s1_nxt;
    end
    if (rdy[2]) begin
      s2_r <= s2_nxt;
    end
    if (rdy[3]) begin
      s3_r <= s3_nxt;
    end
    if (rdy[4]) begin
      s4_r <= s4_nxt;
    end
    if (rdy[5]) begin
      s5_r <= s5_nxt;
    end
    if (rdy[6]) begin
      s6_r <= s6_nxt;
    end
    if (rdy[7]) begin
      s7_r <= s7_nxt;
    end
  end

  assign out_tdata = {3'b000,
                      s7_r.hdig.units, s7_r.hdig.tens, s7_r.hdig.hund, s7_r.hdig.thou,
                      s7_r.tdig.units, s7_r.tdig.tens, s7_r.tdig.hund, s7_r.tdig.thou,
                      s7_r.humi, s7_r.temp};

endmodule

@@ bench/htc_reading_checker.sv @@
// ----------------------------------------------------------------------------
// htc_reading_checker: result checker for humidity/temperature compensation
// Watches the reading, result and offset-write ports. It converts each
// accepted reading to the expected tenths and digits and compares each
// result, field by field, with the oldest reading still waiting.
// ----------------------------------------------------------------------------
module htc_reading_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [31:0] in_tdata,
  input  logic        in_tuser,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [63:0] out_tdata,
  input  logic        cfg_we,
  input  logic [13:0] cfg_wdata,
  output int          mismatch_count,
  output int          readings_waiting,
  output int          results_checked
);

  typedef struct {
    logic signed [14:0] temp;
    logic [13:0]        humi;
    htc_pkg::digits_t   tdig;
    htc_pkg::digits_t   hdig;
  } reading_t;

  typedef int field_vals_t[10];

  localparam string FIELD_NAME[10] = '{
    "temp_tenths", "humi_tenths",
    "temp_digit_thousands", "temp_digit_hundreds", "temp_digit_tens", "temp_digit_units",
    "humi_digit_thousands", "humi_digit_hundreds", "humi_digit_tens", "humi_digit_units"
  };

  logic signed [13:0] offset_centi;
  reading_t           pending_readings[$];
  reading_t           want;
  reading_t           got;
  field_vals_t        want_f;
  field_vals_t        got_f;

  function automatic htc_pkg::digits_t decimal_digits(input longint mag);
    htc_pkg::digits_t d;
    d.thou  = 4'((mag / 1000) % 10);
    d.hund  = 4'((mag / 100) % 10);
    d.tens  = 4'((mag / 10) % 10);
    d.units = 4'(mag % 10);
    return d;
  endfunction

  // Exact integer form: temperature in hundredths, humidity in 1e-7 %RH
  function automatic reading_t convert_reading(input logic [11:0] h_ticks,
                                               input logic [13:0] t_ticks,
                                               input logic err,
                                               input logic signed [13:0] off);
    longint   h;
    longint   tc;
    longint   v;
    longint   temp_t;
    longint   humi_t;
    reading_t r;
    h = longint'(h_ticks);
    if (err) begin
      temp_t = 9999;
      humi_t = 9999;
    end else begin
      tc = longint'(t_ticks) + longint'(off);
      v  = -28 * h * h + 405000 * h - 40000000 + (tc - 2500) * (1000 + 8 * h);
      temp_t = tc / 10;
      if (v > 64'sd1000000000)
        humi_t = 1000;
      else if (v < 64'sd1000000)
        humi_t = 1;
      else
        humi_t = v / 1000000;
    end
    r.temp = 15'(temp_t);
    r.humi = 14'(humi_t);
    r.tdig = decimal_digits(temp_t < 0 ? -temp_t : temp_t);
    r.hdig = decimal_digits(humi_t);
    return r;
  endfunction

  function automatic field_vals_t fields_of(input reading_t r);
    return '{int'(r.temp), int'(r.humi),
             int'(r.tdig.thou), int'(r.tdig.hund), int'(r.tdig.tens), int'(r.tdig.units),
             int'(r.hdig.thou), int'(r.hdig.hund), int'(r.hdig.tens), int'(r.hdig.units)};
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      offset_centi = htc_pkg::TEMP_OFFSET_RESET;
      pending_readings.delete();
      mismatch_count  = 0;
      results_checked = 0;
    end else begin
      if (in_tvalid && in_tready)
        pending_readings.push_back(convert_reading(in_tdata[11:0], in_tdata[25:12],
                                                   in_tuser, offset_centi));
      if (out_tvalid && out_tready) begin
        if (pending_readings.size() == 0) begin
          mismatch_count++;
          $display("%0t: result with no reading waiting, got tdata %h", $time, out_tdata);
        end else begin
          want      = pending_readings.pop_front();
          got.temp  = out_tdata[14:0];
          got.humi  = out_tdata[28:15];
          got.tdig  = {out_tdata[32:29], out_tdata[36:33], out_tdata[40:37], out_tdata[44:41]};
          got.hdig  = {out_tdata[48:45], out_tdata[52:49], out_tdata[56:53], out_tdata[60:57]};
          want_f    = fields_of(want);
          got_f     = fields_of(got);
          results_checked++;
          for (int i = 0; i < 10; i++)
            if (want_f[i] != got_f[i]) begin
              mismatch_count++;
              $display("%0t: %s expected %0d, got %0d", $time, FIELD_NAME[i],
                       want_f[i], got_f[i]);
            end
        end
      end
      // write lands after this edge's reading, matching the block
      if (cfg_we)
        offset_centi = cfg_wdata;
    end
    readings_waiting = pending_readings.size();
  end

endmodule

@@ bench/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top: testbench for humidity_temperature_compensation
// Drives raw sensor readings and offset writes, with random gaps on the
// reading side and random stalls on the result side. A checker beside the
// block predicts every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;

  localparam int NUM_PHASES       = 7;
  localparam int READINGS_PER_PHASE = 280;
  localparam int HOLD_CYCLES      = 200;  // long result-side stall
  localparam int DRAIN_CYCLES     = 20;   // past the 7-stage pipeline
  localparam int CYCLE_LIMIT      = 100000;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [31:0] in_tdata = '0;   // raw_humidity[11:0], raw_temperature[25:12], zero fill
  logic        in_tuser = 1'b0; // sensor_error[0]
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [63:0] out_tdata;       // temp_tenths, humi_tenths, 4 temp digits, 4 humi digits
  logic        cfg_we = 1'b0;
  logic [13:0] cfg_wdata = '0;

  int mismatch_count;
  int readings_waiting;
  int results_checked;

  // gap/stall odds in percent, updated per phase
  int  send_idle = 0;
  int  take_idle = 0;
  bit  hold_request = 1'b0;
  int  readings_sent = 0;

  always #5 clk = ~clk;

  humidity_temperature_compensation dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata)
  );

  htc_reading_checker chk (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .in_tuser         (in_tuser),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .mismatch_count   (mismatch_count),
    .readings_waiting (readings_waiting),
    .results_checked  (results_checked)
  );

  // Offer one reading; called and returns at a falling edge.
  // Random gaps first, then hold valid until the block takes the item.
  task automatic push_reading(input logic [11:0] h, input logic [13:0] t, input logic err);
    while ($urandom_range(0, 99) < send_idle) begin
      in_tvalid <= 1'b0;
      in_tdata  <= {6'b0, 26'($urandom)};  // junk while idle
      in_tuser  <= 1'($urandom);
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {6'b0, t, h};
    in_tuser  <= err;
    do @(posedge clk); while (!in_tready);
    readings_sent++;
    @(negedge clk);
  endtask

  // Let every expected result come back, then wait DRAIN_CYCLES more
  task automatic drain_pipeline();
    in_tvalid <= 1'b0;
    while (readings_waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Offset register write, only with the pipeline empty
  task automatic write_offset(input logic signed [13:0] off);
    cfg_we    <= 1'b1;
    cfg_wdata <= off;
    @(negedge clk);
    cfg_we    <= 1'b0;
    @(negedge clk);
  endtask

  // Result side: random stalls, plus one long hold on request
  initial begin
    forever begin
      @(negedge clk);
      if (hold_request) begin
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_request = 1'b0;
      end
      out_tready <= ($urandom_range(0, 99) >= take_idle);
    end
  end

  // Watchdog
  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("humidity_temperature_compensation: mismatch");
    $finish;
  end

  initial begin
    logic signed [13:0] phase_offset[NUM_PHASES];
    logic [11:0]        h;
    logic [13:0]        t;
    logic               err;
    int                 sel;
    longint             base;
    longint             span;
    longint             rem;
    longint             target;
    longint             t_fit;
    bit                 found;

    // Offsets per phase: stated range ends, mid range, the 14-bit extremes,
    // back to reset value, then anything the field allows
    phase_offset[0] = -14'sd4100;
    phase_offset[1] = -14'sd3900;
    phase_offset[2] = 14'(int'($urandom_range(0, 200)) - 4100);
    phase_offset[3] = -14'sd8192;
    phase_offset[4] = 14'sd8191;
    phase_offset[5] = htc_pkg::TEMP_OFFSET_RESET;
    phase_offset[6] = 14'($urandom);

    repeat (12) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // ---- directed readings, offset still at reset value (-40.00) ----
    push_reading(12'd0,    14'd0,     1'b0);  // coldest, humidity clamps low
    push_reading(12'd4095, 14'd16383, 1'b0);  // hottest, humidity clamps high
    push_reading(12'd4095, 14'd0,     1'b0);  // max ticks, cold: in range
    push_reading(12'd4095, 14'd16383, 1'b1);  // sensor error, all fields ones
    push_reading(12'd0,    14'd0,     1'b1);  // sensor error, all fields zero
    push_reading(12'hAAA,  14'h1555,  1'b0);  // alternating bit patterns
    push_reading(12'h555,  14'h2AAA,  1'b0);
    push_reading(12'd1500, 14'd6500,  1'b0);  // exactly 25.00 degC, no compensation
    push_reading(12'd2000, 14'd3000,  1'b0);  // negative temperature
    push_reading(12'd1000, 14'd3995,  1'b0);  // -0.05: truncates to zero
    push_reading(12'd1000, 14'd3990,  1'b0);  // -0.10: first negative tenth
    push_reading(12'd1000, 14'd3989,  1'b0);  // -0.11
    push_reading(12'd100,  14'd4000,  1'b0);  // exactly 0 degC

    // Readings that land exactly on 0.1 %RH and on 100 %RH, if any exist
    // at this offset: solve the humidity sum for the temperature ticks
    for (int k = 0; k < 2; k++) begin
      target = (k == 0) ? 64'sd1000000 : 64'sd1000000000;
      found  = 1'b0;
      for (int hh = 0; hh < 4096 && !found; hh++) begin
        base = -28 * longint'(hh) * hh + 405000 * longint'(hh) - 40000000;
        span = 1000 + 8 * longint'(hh);
        rem  = target - base;
        if (rem % span == 0) begin
          t_fit = rem / span + 2500 - longint'(htc_pkg::TEMP_OFFSET_RESET);
          if (t_fit >= 0 && t_fit <= 16383) begin
            found = 1'b1;
            push_reading(12'(hh), 14'(t_fit), 1'b0);
          end
        end
      end
    end
    drain_pipeline();

    // ---- random phases, one offset each ----
    for (int p = 0; p < NUM_PHASES; p++) begin
      write_offset(phase_offset[p]);
      if (p < 3) begin
        send_idle = 35;
        take_idle = 53;
      end else if (p < 5) begin
        send_idle = 53;
        take_idle = 35;
      end else begin
        send_idle = 0;
        take_idle = 0;
      end
      for (int n = 0; n < READINGS_PER_PHASE; n++) begin
        // full-speed phase: stall the result side long enough to back up
        // the whole pipeline while readings keep coming
        if (p == 5 && n == 40)
          hold_request = 1'b1;
        sel = $urandom_range(0, 19);
        h   = 12'($urandom);
        t   = 14'($urandom);
        err = (sel < 2);
        case (sel)
          2: h = 12'd0;
          3: h = 12'd4095;
          4: t = 14'd0;
          5: t = 14'd16383;
          default: begin
            // plausible room readings: humidity mostly inside the clamps
            if (sel >= 6 && sel <= 13) begin
              h = 12'($urandom_range(200, 3600));
              t = 14'($urandom_range(3000, 9000));
            end
          end
        endcase
        push_reading(h, t, err);
      end
      drain_pipeline();
    end

    $display("Run covered %0d readings, %0d results checked, over %0d offset settings",
             readings_sent, results_checked, NUM_PHASES + 1);
    $display("including sensor errors, clamps at both ends, negative and zero temperatures");
    if (mismatch_count == 0 && readings_waiting == 0)
      $display("humidity_temperature_compensation: match");
    else
      $display("humidity_temperature_compensation: mismatch");
    $finish;
  end

endmodule

@@ filelist.f @@
src/htc_pkg.sv
src/humidity_temperature_compensation.sv
bench/htc_reading_checker.sv
bench/tb_top.sv
